### src/pngu_pkg.sv
// shared types and constants for the png scanline unfilter
// no dependencies; every other file in src except pngu_checker refers to this package by scoped names
`default_nettype none

package pngu_pkg;

    localparam int MAX_ROW_BYTES   = 16384;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int COL_W     = $clog2(MAX_ROW_BYTES);
    localparam int RLEN_W    = COL_W + 1;
    localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int PLEN_W    = 4;
    localparam int ROW_W     = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS      = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // effective configuration, already clamped into range
    typedef struct packed {
        logic [RLEN_W-1:0] row_len;
        logic [PLEN_W-1:0] pix_len;
        logic [ROW_W-1:0]  rows;
    } cfg_t;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [7:0]       data;
        filter_t          filter;
        logic [COL_W-1:0] col;
        logic             has_above;
        logic             has_left;
        logic             last_col;
        logic             last_row;
        logic             bad;
    } entry_t;

endpackage

`default_nettype wire

### src/pngu_front.sv
// front end: accepts stream bytes, tracks row and column, classifies each byte
// depends on pngu_pkg
`default_nettype none

module pngu_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pngu_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      data_byte,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output pngu_pkg::entry_t     q_entry
);

    logic                            awaiting_reg, awaiting_next;
    logic                            error_reg, error_next;
    pngu_pkg::filter_t               filter_reg, filter_next;
    logic [pngu_pkg::COL_W-1:0]      col_reg, col_next;
    logic [pngu_pkg::ROW_W-1:0]      row_reg, row_next;

    logic                            accept;
    logic                            bad;
    logic                            last_col;
    logic                            last_row;
    logic                            has_left;
    logic [pngu_pkg::RLEN_W-1:0]     col_inc;
    logic [pngu_pkg::ROW_W:0]        row_inc;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    assign bad      = data_byte > {5'd0, pngu_pkg::FILT_PAETH};
    assign col_inc  = {1'b0, col_reg} + pngu_pkg::RLEN_W'(1);
    assign row_inc  = {1'b0, row_reg} + (pngu_pkg::ROW_W + 1)'(1);
    assign last_col = col_inc >= cfg.row_len;
    assign last_row = row_inc >= {1'b0, cfg.rows};
    assign has_left = col_reg >= pngu_pkg::COL_W'(cfg.pix_len);

    // a filter byte only pushes when it is the error
    assign q_valid = in_valid && !error_reg && (!awaiting_reg || bad);

    always_comb
    begin
        q_entry.data      = data_byte;
        q_entry.filter    = filter_reg;
        q_entry.col       = col_reg;
        q_entry.has_above = row_reg != '0;
        q_entry.has_left  = has_left;
        q_entry.last_col  = last_col;
        q_entry.last_row  = last_col && last_row;
        q_entry.bad       = awaiting_reg;
    end

    always_comb
    begin
        awaiting_next = awaiting_reg;
        error_next    = error_reg;
        filter_next   = filter_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (accept && !error_reg)
        begin
            if (awaiting_reg)
            begin
                if (bad)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    filter_next   = pngu_pkg::filter_t'(data_byte[2:0]);
                    awaiting_next = 1'b0;
                end
            end
            else if (last_col)
            begin
                col_next      = '0;
                awaiting_next = 1'b1;
                row_next      = last_row ? '0 : row_inc[pngu_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[pngu_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            error_reg    <= 1'b0;
            filter_reg   <= pngu_pkg::FILT_NONE;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            error_reg    <= error_next;
            filter_reg   <= filter_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

endmodule

`default_nettype wire

### src/pngu_queue.sv
// short first-in first-out queue of classified entries between front and back
// depends on pngu_pkg
`default_nettype none

module pngu_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire pngu_pkg::entry_t  push_entry,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output pngu_pkg::entry_t       pop_entry
);

    pngu_pkg::entry_t                store_reg [pngu_pkg::QUEUE_DEPTH];
    logic [pngu_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pngu_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pngu_pkg::QUEUE_AW:0]     count_reg, count_next;
    logic                            push;
    logic                            pop;

    assign push_ready = count_reg != (pngu_pkg::QUEUE_AW + 1)'(pngu_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = store_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + pngu_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + pngu_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (pngu_pkg::QUEUE_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (pngu_pkg::QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/pngu_back.sv
// back end: prior row memory, neighbor history, reconstruction and output register
// depends on pngu_pkg
`default_nettype none

module pngu_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pngu_pkg::cfg_t    cfg,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire pngu_pkg::entry_t  q_entry,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             pixel_byte,
    output logic                   row_end,
    output logic                   image_end,
    output logic                   bad_filter
);

    // prior row store, no reset: a read value is only used after the row above wrote it
    logic [7:0]                      prior_mem [pngu_pkg::MAX_ROW_BYTES];
    logic [7:0]                      rd_data_reg;
    logic                            fwd_reg;
    logic [7:0]                      fwd_data_reg;

    logic [7:0]                      cur_hist_reg [pngu_pkg::MAX_PIXEL_BYTES];
    logic [7:0]                      above_hist_reg [pngu_pkg::MAX_PIXEL_BYTES];

    pngu_pkg::entry_t                s1_reg;
    logic                            s1_vld_reg;

    logic                            out_vld_reg;
    logic [7:0]                      pix_out_reg;
    logic                            row_end_reg;
    logic                            image_end_reg;
    logic                            bad_reg;

    logic                            advance;
    logic                            s1_go;
    logic                            s1_write;
    logic                            load;
    logic                            pop;
    logic [pngu_pkg::PIX_IDX_W-1:0]  back_idx;
    logic [pngu_pkg::PLEN_W-1:0]     back_dist;
    logic [7:0]                      b_raw;
    logic [7:0]                      a_nb;
    logic [7:0]                      b_nb;
    logic [7:0]                      c_nb;
    logic [8:0]                      avg_sum;
    logic [7:0]                      pred;
    logic [7:0]                      pix;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] d_bc;
        logic signed [9:0] d_ac;
        logic signed [9:0] d_sum;
        logic [8:0]        pa;
        logic [8:0]        pb;
        logic [8:0]        pc;
        d_bc  = signed'({2'b00, b}) - signed'({2'b00, c});
        d_ac  = signed'({2'b00, a}) - signed'({2'b00, c});
        d_sum = d_bc + d_ac;
        pa    = d_bc[9] ? 9'(-d_bc) : d_bc[8:0];
        pb    = d_ac[9] ? 9'(-d_ac) : d_ac[8:0];
        pc    = d_sum[9] ? 9'(-d_sum) : d_sum[8:0];
        if (pa <= pb && pa <= pc)
        begin
            return a;
        end
        else if (pb <= pc)
        begin
            return b;
        end
        else
        begin
            return c;
        end
    endfunction

    assign advance  = !out_vld_reg || out_ready;
    assign s1_go    = s1_vld_reg && advance;
    assign s1_write = s1_go && !s1_reg.bad;
    assign load     = !s1_vld_reg || advance;
    assign q_ready  = load;
    assign pop      = q_valid && load;

    assign back_dist = cfg.pix_len - pngu_pkg::PLEN_W'(1);
    assign back_idx  = back_dist[pngu_pkg::PIX_IDX_W-1:0];

    assign b_raw = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign a_nb  = s1_reg.has_left ? cur_hist_reg[back_idx] : 8'd0;
    assign b_nb  = s1_reg.has_above ? b_raw : 8'd0;
    assign c_nb  = (s1_reg.has_above && s1_reg.has_left) ? above_hist_reg[back_idx] : 8'd0;

    assign avg_sum = {1'b0, a_nb} + {1'b0, b_nb};

    always_comb
    begin
        case (s1_reg.filter)
            pngu_pkg::FILT_NONE:  pred = 8'd0;
            pngu_pkg::FILT_SUB:   pred = a_nb;
            pngu_pkg::FILT_UP:    pred = b_nb;
            pngu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pngu_pkg::FILT_PAETH: pred = paeth(a_nb, b_nb, c_nb);
            default:              pred = 8'd0;
        endcase
    end

    assign pix = s1_reg.data + pred;

    // memory port: write from stage one, read for the entry entering stage one
    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            prior_mem[s1_reg.col] <= pix;
        end
        if (pop)
        begin
            rd_data_reg  <= prior_mem[q_entry.col];
            fwd_reg      <= s1_write && (s1_reg.col == q_entry.col);
            fwd_data_reg <= pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pngu_pkg::MAX_PIXEL_BYTES; i++)
            begin
                cur_hist_reg[i]   <= 8'd0;
                above_hist_reg[i] <= 8'd0;
            end
        end
        else if (s1_write)
        begin
            for (int i = pngu_pkg::MAX_PIXEL_BYTES - 1; i > 0; i--)
            begin
                cur_hist_reg[i]   <= cur_hist_reg[i-1];
                above_hist_reg[i] <= above_hist_reg[i-1];
            end
            cur_hist_reg[0]   <= pix;
            above_hist_reg[0] <= b_nb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg <= q_entry;
        end
        if (advance)
        begin
            pix_out_reg   <= s1_reg.bad ? 8'd0 : pix;
            row_end_reg   <= s1_reg.last_col && !s1_reg.bad;
            image_end_reg <= s1_reg.last_row && !s1_reg.bad;
            bad_reg       <= s1_reg.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_vld_reg <= q_valid;
            end
            if (advance)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    assign out_valid  = out_vld_reg;
    assign pixel_byte = pix_out_reg;
    assign row_end    = row_end_reg;
    assign image_end  = image_end_reg;
    assign bad_filter = bad_reg;

endmodule

`default_nettype wire

### src/png_scanline_unfilter.sv
// top level of the png scanline unfilter: config registers, front, queue and back
// depends on pngu_pkg, pngu_front, pngu_queue and pngu_back
// path: a pixel byte passes through the queue, the stage one register and the output register
// throughput: one byte per cycle while out_ready holds, set by the combinational reconstruct and prior row port
// reset: rst_n async low clears control, config back to 1/1/1, next byte is a filter type
`default_nettype none

module png_scanline_unfilter
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pngu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pngu_pkg::CFG_DATA_W-1:0]    cfg_data,
    // filtered byte stream in
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         data_byte,
    // reconstructed bytes out
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [7:0]                              pixel_byte,
    output logic                                    row_end,
    output logic                                    image_end,
    output logic                                    bad_filter
);

    pngu_pkg::cfg_t      cfg_reg, cfg_next;
    logic                q_push_valid;
    logic                q_push_ready;
    pngu_pkg::entry_t    q_push_entry;
    logic                q_pop_valid;
    logic                q_pop_ready;
    pngu_pkg::entry_t    q_pop_entry;
    logic                cfg_write;

    // config writes go straight into the config register, so the port is always ready
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // values are clamped on write so the datapath only sees legal lengths
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                pngu_pkg::CFG_ROW_BYTES:
                begin
                    if (cfg_data[pngu_pkg::RLEN_W-1:0] == '0)
                    begin
                        cfg_next.row_len = pngu_pkg::RLEN_W'(1);
                    end
                    else if (cfg_data[pngu_pkg::RLEN_W-1:0] >
                             pngu_pkg::RLEN_W'(pngu_pkg::MAX_ROW_BYTES))
                    begin
                        cfg_next.row_len = pngu_pkg::RLEN_W'(pngu_pkg::MAX_ROW_BYTES);
                    end
                    else
                    begin
                        cfg_next.row_len = cfg_data[pngu_pkg::RLEN_W-1:0];
                    end
                end
                pngu_pkg::CFG_BYTES_PER_PIXEL:
                begin
                    if (cfg_data[pngu_pkg::PLEN_W-1:0] == '0)
                    begin
                        cfg_next.pix_len = pngu_pkg::PLEN_W'(1);
                    end
                    else if (cfg_data[pngu_pkg::PLEN_W-1:0] >
                             pngu_pkg::PLEN_W'(pngu_pkg::MAX_PIXEL_BYTES))
                    begin
                        cfg_next.pix_len = pngu_pkg::PLEN_W'(pngu_pkg::MAX_PIXEL_BYTES);
                    end
                    else
                    begin
                        cfg_next.pix_len = cfg_data[pngu_pkg::PLEN_W-1:0];
                    end
                end
                pngu_pkg::CFG_IMAGE_ROWS:
                begin
                    if (cfg_data[pngu_pkg::ROW_W-1:0] == '0)
                    begin
                        cfg_next.rows = pngu_pkg::ROW_W'(1);
                    end
                    else
                    begin
                        cfg_next.rows = cfg_data[pngu_pkg::ROW_W-1:0];
                    end
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_len <= pngu_pkg::RLEN_W'(1);
            cfg_reg.pix_len <= pngu_pkg::PLEN_W'(1);
            cfg_reg.rows    <= pngu_pkg::ROW_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: row/column bookkeeping, filter type capture and error latch;
    // filter bytes are consumed here and only the error is passed on
    pngu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .q_valid   (q_push_valid),
        .q_ready   (q_push_ready),
        .q_entry   (q_push_entry)
    );

    // queue decouples the input from output stalls; its ready is registered
    pngu_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_entry (q_push_entry),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_entry  (q_pop_entry)
    );

    // back: prior row read, neighbor select, predictor and output register;
    // a same-column write in flight is forwarded to the read for one-byte rows
    pngu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_pop_valid),
        .q_ready    (q_pop_ready),
        .q_entry    (q_pop_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_byte (pixel_byte),
        .row_end    (row_end),
        .image_end  (image_end),
        .bad_filter (bad_filter)
    );

endmodule

`default_nettype wire

### src/pngu_checker.sv
// port-level checks on the png scanline unfilter, with the bind that attaches them
// depends on png_scanline_unfilter
`default_nettype none

module pngu_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  pixel_byte,
    input wire logic        row_end,
    input wire logic        image_end,
    input wire logic        bad_filter
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // the last byte of an image also closes its row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_end |-> row_end)
        else $error("image end without row end");

    // error transaction carries an empty payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_filter |-> pixel_byte == 8'd0 && !row_end && !image_end)
        else $error("error result with payload");

    // nothing follows an error transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && bad_filter |=> !out_valid)
        else $error("result after error");

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_byte (pixel_byte),
    .row_end    (row_end),
    .image_end  (image_end),
    .bad_filter (bad_filter)
);

`default_nettype wire
